/* design/pfrr_pkg.sv */
// Package for the proportional font row renderer.
// Field widths, run limit, function codes and the sequencer state type.
// Used by pfrr_ram's users; no dependencies of its own.
`default_nettype none

package pfrr_pkg;

    // default sizes of the stores and the glyph width clamp
    localparam int BITMAP_WORDS_DEF    = 16384;
    localparam int GLYPH_ENTRIES_DEF   = 257;
    localparam int MAX_GLYPH_WIDTH_DEF = 64;

    // fixed field widths
    localparam int ROW_WORDS_W = 11;
    localparam int FUNC_W      = 2;
    localparam int CODE_W      = 9;
    localparam int OFFSET_W    = 15;
    localparam int LEFT_W      = 8;
    localparam int CWIDTH_W    = 7;
    localparam int WADDR_W     = 14;
    localparam int WORD_W      = 32;
    localparam int ROW_W       = 7;
    localparam int SPACES_W    = 16;
    localparam int MARKS_W     = 7;

    // packed metric entry: offset, left bearing, cell width
    localparam int MET_W = OFFSET_W + LEFT_W + CWIDTH_W;

    // word index width: covers row * row_words + column / 32 and any store depth
    localparam int WIDX_W = 21;

    // runs reported per render word before marks turn to blanks
    localparam int RUN_LIMIT = 32;
    localparam int RUNS_W    = 6;

    localparam logic [ROW_WORDS_W-1:0] ROW_WORDS_RESET = 11'd1;
    localparam logic [SPACES_W-1:0]    SPACES_MAX      = 16'hFFFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_METRIC = 2'd0,
        FUNC_LOAD_WORD   = 2'd1,
        FUNC_RENDER      = 2'd2,
        FUNC_END_ROW     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MET0,
        ST_MET1,
        ST_COL,
        ST_FETCH,
        ST_FIN,
        ST_LAST,
        ST_EOR
    } state_t;

endpackage

`default_nettype wire

/* design/pfrr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the glyph metric table and the bitmap store; no package needed.
`default_nettype none

module pfrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, then registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/proportional_font_row_renderer_core.sv */
// Top level of the proportional font row renderer: sequencer, run builder, output register.
// Depends on pfrr_pkg and two pfrr_ram instances (metric table, bitmap store).
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------------
//  cfg      | in        | cfg_wr_en         | cfg_wr_data (row_words)
//  s_       | in        | s_valid / s_ready | func, code, glyph metrics, word, pixel_row
//  m_       | out       | m_valid / m_ready | spaces_before, mark_count, is_newline, last
//
// Loads are taken in the idle state. A render reads the metrics (ST_MET0, ST_MET1), steps
// once per cell column plus once at the cell edge, fetches each bitmap word needed (at most
// three per glyph row), then flushes the held run (ST_FIN, ST_LAST) and returns to idle.
// End of row passes through ST_EOR. The column walk uses the single bitmap read port.
// Reset clears control state and sets row_words to 1; both memories hold undefined data.
// A full output register stalls the walk at the next run boundary; no word is dropped.
`default_nettype none

module proportional_font_row_renderer_core
    import pfrr_pkg::*;
#(
    parameter int BITMAP_WORDS    = BITMAP_WORDS_DEF,
    parameter int GLYPH_ENTRIES   = GLYPH_ENTRIES_DEF,
    parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_wr_en,
    input  wire logic [ROW_WORDS_W-1:0]   cfg_wr_data,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [FUNC_W-1:0]        s_func,
    input  wire logic [CODE_W-1:0]        s_code,
    input  wire logic [OFFSET_W-1:0]      s_glyph_offset,
    input  wire logic signed [LEFT_W-1:0] s_glyph_left,
    input  wire logic [CWIDTH_W-1:0]      s_glyph_cell_width,
    input  wire logic [WADDR_W-1:0]       s_word_address,
    input  wire logic [WORD_W-1:0]        s_word_value,
    input  wire logic [ROW_W-1:0]         s_pixel_row,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [SPACES_W-1:0]           m_spaces_before,
    output logic [MARKS_W-1:0]            m_mark_count,
    output logic                          m_is_newline,
    output logic                          m_last
);

    localparam int MA_W = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int BA_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [7:0]        MAX_W8     = 8'(MAX_GLYPH_WIDTH);
    localparam logic [CODE_W:0]   GLYPH_LIM  = (CODE_W + 1)'(GLYPH_ENTRIES);
    localparam logic [31:0]       BITMAP_LIM = 32'(BITMAP_WORDS);
    localparam logic [RUNS_W-1:0] RUN_LIM    = RUNS_W'(RUN_LIMIT);

    // ---------------------------------------------------------------- registers
    state_t                   state_reg, state_next;
    logic [ROW_WORDS_W-1:0]   row_words_reg;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [OFFSET_W-1:0]      x_reg, x_next;
    logic signed [LEFT_W-1:0] l_reg, l_next;
    logic [CWIDTH_W-1:0]      w_reg, w_next;
    logic signed [15:0]       dx_reg, dx_next;
    logic [17:0]              base_reg, base_next;
    logic [CWIDTH_W-1:0]      i_reg, i_next;
    logic [MARKS_W-1:0]       marks_reg, marks_next;
    logic [RUNS_W-1:0]        n_reg, n_next;
    logic [SPACES_W-1:0]      pending_reg, pending_next;
    logic [SPACES_W-1:0]      run_spaces_reg, run_spaces_next;
    logic                     h_valid_reg, h_valid_next;
    logic [SPACES_W-1:0]      h_spaces_reg, h_spaces_next;
    logic [MARKS_W-1:0]       h_marks_reg, h_marks_next;
    logic                     cache_valid_reg, cache_valid_next;
    logic [WIDX_W-1:0]        cache_idx_reg, cache_idx_next;
    logic [WORD_W-1:0]        cache_word_reg, cache_word_next;
    logic                     out_valid_reg;
    logic [SPACES_W-1:0]      out_spaces_reg;
    logic [MARKS_W-1:0]       out_marks_reg;
    logic                     out_newline_reg;
    logic                     out_last_reg;

    // ---------------------------------------------------------------- memories
    logic             met_we, met_re;
    logic [MA_W-1:0]  met_waddr, met_raddr;
    logic [MET_W-1:0] met_wdata, met_rdata;
    logic             bm_we, bm_re;
    logic [BA_W-1:0]  bm_waddr, bm_raddr;
    logic [WORD_W-1:0] bm_rdata;

    pfrr_ram #(.WIDTH(MET_W), .DEPTH(GLYPH_ENTRIES)) u_metrics (
        .aclk  (aclk),
        .we    (met_we),
        .waddr (met_waddr),
        .wdata (met_wdata),
        .re    (met_re),
        .raddr (met_raddr),
        .rdata (met_rdata)
    );

    pfrr_ram #(.WIDTH(WORD_W), .DEPTH(BITMAP_WORDS)) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (s_word_value),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // ---------------------------------------------------------------- input decode
    logic                accept;
    logic [CODE_W:0]     code_in_ext;
    logic [CODE_W:0]     code1;
    logic                code_in_ok, code1_ok;
    logic [CWIDTH_W-1:0] w_clamp;
    logic [WIDX_W-1:0]   waddr_ext;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign code_in_ext = {1'b0, s_code};
    assign code_in_ok  = code_in_ext < GLYPH_LIM;
    assign code1       = {1'b0, code_reg} + (CODE_W + 1)'(1);
    assign code1_ok    = code1 < GLYPH_LIM;
    assign w_clamp     = ({1'b0, s_glyph_cell_width} > MAX_W8) ? MAX_W8[CWIDTH_W-1:0]
                                                               : s_glyph_cell_width;
    assign waddr_ext   = WIDX_W'(s_word_address);

    // write the stores straight from an accepted load word
    assign met_we    = accept && (func_t'(s_func) == FUNC_LOAD_METRIC) && code_in_ok;
    assign met_waddr = code_in_ext[MA_W-1:0];
    assign met_wdata = {w_clamp, s_glyph_left, s_glyph_offset};
    assign bm_we     = accept && (func_t'(s_func) == FUNC_LOAD_WORD)
                       && ({11'b0, waddr_ext} < BITMAP_LIM);
    assign bm_waddr  = waddr_ext[BA_W-1:0];

    // ---------------------------------------------------------------- column decode
    logic signed [17:0] i_s, l_s, lim_s, col_s;
    logic [OFFSET_W-1:0] col;
    logic [WIDX_W-1:0]   widx;
    logic in_ext, allow, need_pix, in_rng, hit, i_done, fetch, pix;
    logic run_end, out_busy, stall_col, stall_fin;

    assign i_s      = $signed({11'b0, i_reg});
    assign l_s      = 18'(l_reg);
    assign lim_s    = 18'(dx_reg) + l_s;
    assign col_s    = $signed({3'b0, x_reg}) + i_s - l_s;
    assign col      = col_s[OFFSET_W-1:0];
    assign widx     = WIDX_W'(base_reg) + WIDX_W'(col[OFFSET_W-1:5]);
    assign in_ext   = (i_s >= l_s) && (i_s < lim_s);
    assign allow    = (marks_reg != '0) || (n_reg < RUN_LIM);
    assign need_pix = in_ext && allow;
    assign in_rng   = {11'b0, widx} < BITMAP_LIM;
    assign hit      = cache_valid_reg && (cache_idx_reg == widx);
    assign i_done   = (i_reg == w_reg);
    assign fetch    = !i_done && need_pix && in_rng && !hit;
    assign pix      = need_pix && in_rng && cache_word_reg[5'd31 - col[4:0]];
    assign run_end  = !pix && (marks_reg != '0);
    assign out_busy = out_valid_reg && !m_ready;
    assign stall_col = run_end && h_valid_reg && out_busy;
    assign stall_fin = (marks_reg != '0) && h_valid_reg && out_busy;

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (func_t'(s_func) == FUNC_RENDER)) begin
                    state_next = ST_MET0;
                end else if (accept && (func_t'(s_func) == FUNC_END_ROW)) begin
                    state_next = ST_EOR;
                end
            end
            ST_MET0:  state_next = ST_MET1;
            ST_MET1:  state_next = ST_COL;
            ST_COL: begin
                if (i_done) begin
                    state_next = ST_FIN;
                end else if (fetch) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_COL;
            ST_FIN: begin
                if (!stall_fin) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (!(h_valid_reg && out_busy)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EOR: begin
                if (!out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath and outputs
    logic                out_load;
    logic [SPACES_W-1:0] out_spaces_d;
    logic [MARKS_W-1:0]  out_marks_d;
    logic                out_newline_d, out_last_d;

    always_comb begin
        code_next        = code_reg;
        row_next         = row_reg;
        x_next           = x_reg;
        l_next           = l_reg;
        w_next           = w_reg;
        dx_next          = dx_reg;
        base_next        = base_reg;
        i_next           = i_reg;
        marks_next       = marks_reg;
        n_next           = n_reg;
        pending_next     = pending_reg;
        run_spaces_next  = run_spaces_reg;
        h_valid_next     = h_valid_reg;
        h_spaces_next    = h_spaces_reg;
        h_marks_next     = h_marks_reg;
        cache_valid_next = cache_valid_reg;
        cache_idx_next   = cache_idx_reg;
        cache_word_next  = cache_word_reg;
        met_re           = 1'b0;
        met_raddr        = code_in_ext[MA_W-1:0];
        bm_re            = 1'b0;
        bm_raddr         = widx[BA_W-1:0];
        out_load         = 1'b0;
        out_spaces_d     = h_spaces_reg;
        out_marks_d      = h_marks_reg;
        out_newline_d    = 1'b0;
        out_last_d       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                // latch the word and start the metric read of the glyph
                if (accept) begin
                    code_next = s_code;
                    row_next  = s_pixel_row;
                    met_re    = (func_t'(s_func) == FUNC_RENDER) && code_in_ok;
                end
            end
            ST_MET0: begin
                // take this glyph's metrics, read the next glyph's offset
                if (code1 <= GLYPH_LIM) begin
                    x_next = code1_ok || (code1 == GLYPH_LIM) ? met_rdata[OFFSET_W-1:0] : '0;
                end
                if ((code1 - (CODE_W + 1)'(1)) < GLYPH_LIM) begin
                    x_next = met_rdata[OFFSET_W-1:0];
                    l_next = met_rdata[OFFSET_W +: LEFT_W];
                    w_next = met_rdata[OFFSET_W + LEFT_W +: CWIDTH_W];
                end else begin
                    x_next = '0;
                    l_next = '0;
                    w_next = '0;
                end
                met_re    = code1_ok;
                met_raddr = code1[MA_W-1:0];
            end
            ST_MET1: begin
                // extent of the glyph and row base in the strip; reset the walk
                dx_next          = code1_ok ? ($signed({1'b0, met_rdata[OFFSET_W-1:0]})
                                               - $signed({1'b0, x_reg})) : '0;
                base_next        = {11'b0, row_reg} * {7'b0, row_words_reg};
                i_next           = '0;
                marks_next       = '0;
                n_next           = '0;
                h_valid_next     = 1'b0;
                cache_valid_next = 1'b0;
            end
            ST_COL: begin
                if (i_done) begin
                    // hand over to the flush
                end else if (fetch) begin
                    bm_re          = 1'b1;
                    cache_idx_next = widx;
                end else if (!stall_col) begin
                    i_next = i_reg + CWIDTH_W'(1);
                    if (pix) begin
                        if (marks_reg == '0) begin
                            run_spaces_next = pending_reg;
                            pending_next    = '0;
                        end
                        marks_next = marks_reg + MARKS_W'(1);
                    end else begin
                        // close the run: release the held one, hold the new one
                        if (marks_reg != '0) begin
                            out_load      = h_valid_reg;
                            h_valid_next  = 1'b1;
                            h_spaces_next = run_spaces_reg;
                            h_marks_next  = marks_reg;
                            n_next        = n_reg + RUNS_W'(1);
                            marks_next    = '0;
                        end
                        if (pending_reg != SPACES_MAX) begin
                            pending_next = pending_reg + SPACES_W'(1);
                        end
                    end
                end
            end
            ST_FETCH: begin
                cache_word_next  = bm_rdata;
                cache_valid_next = 1'b1;
            end
            ST_FIN: begin
                // close a run still open at the cell edge
                if ((marks_reg != '0) && !stall_fin) begin
                    out_load      = h_valid_reg;
                    h_valid_next  = 1'b1;
                    h_spaces_next = run_spaces_reg;
                    h_marks_next  = marks_reg;
                    n_next        = n_reg + RUNS_W'(1);
                    marks_next    = '0;
                end
            end
            ST_LAST: begin
                // release the final run with last set
                if (h_valid_reg && !out_busy) begin
                    out_load     = 1'b1;
                    out_last_d   = 1'b1;
                    h_valid_next = 1'b0;
                end
            end
            ST_EOR: begin
                // newline word; drop the pending blanks
                if (!out_busy) begin
                    out_load      = 1'b1;
                    out_spaces_d  = '0;
                    out_marks_d   = '0;
                    out_newline_d = 1'b1;
                    out_last_d    = 1'b1;
                    pending_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            row_words_reg   <= ROW_WORDS_RESET;
            pending_reg     <= '0;
            h_valid_reg     <= 1'b0;
            cache_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pending_reg     <= pending_next;
            h_valid_reg     <= h_valid_next;
            cache_valid_reg <= cache_valid_next;
            if (cfg_wr_en) begin
                row_words_reg <= cfg_wr_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        code_reg       <= code_next;
        row_reg        <= row_next;
        x_reg          <= x_next;
        l_reg          <= l_next;
        w_reg          <= w_next;
        dx_reg         <= dx_next;
        base_reg       <= base_next;
        i_reg          <= i_next;
        marks_reg      <= marks_next;
        n_reg          <= n_next;
        run_spaces_reg <= run_spaces_next;
        h_spaces_reg   <= h_spaces_next;
        h_marks_reg    <= h_marks_next;
        cache_idx_reg  <= cache_idx_next;
        cache_word_reg <= cache_word_next;
        if (out_load) begin
            out_spaces_reg  <= out_spaces_d;
            out_marks_reg   <= out_marks_d;
            out_newline_reg <= out_newline_d;
            out_last_reg    <= out_last_d;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_spaces_before = out_spaces_reg;
    assign m_mark_count    = out_marks_reg;
    assign m_is_newline    = out_newline_reg;
    assign m_last          = out_last_reg;

endmodule

`default_nettype wire
